// File: design/lsmt_pkg.sv
package lsmt_pkg;

  // Mode codes as reported on the result channel.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_RENDER = 2'd3;

  // Phase lengths in dots. A vblank line is one full line of dots.
  localparam int unsigned AccumWidth = 10;
  localparam logic [AccumWidth-1:0] DOTS_OAM    = 10'd80;
  localparam logic [AccumWidth-1:0] DOTS_RENDER = 10'd291;
  localparam logic [AccumWidth-1:0] DOTS_HBLANK = 10'd85;
  localparam logic [AccumWidth-1:0] DOTS_LINE   = 10'd456;
  localparam logic [AccumWidth-1:0] ACCUM_MAX   = 10'd1023;

  // Line numbering.
  localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
  localparam logic [7:0] LAST_LINE         = 8'd153;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] CFG_DISPLAY_ENABLE     = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LINE_COMPARE       = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_HBLANK_IRQ_ENABLE  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_VBLANK_IRQ_ENABLE  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_OAM_IRQ_ENABLE     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_COMPARE_IRQ_ENABLE = 3'd5;
  localparam int unsigned CfgDataWidth = 8;

  // Current register settings as seen by the datapath.
  typedef struct packed {
    logic       display_enable;
    logic [7:0] line_compare;
    logic       hblank_irq_enable;
    logic       vblank_irq_enable;
    logic       oam_irq_enable;
    logic       compare_irq_enable;
  } cfg_t;

  // Timer state carried from one tick to the next.
  typedef struct packed {
    logic [1:0]            mode;
    logic [7:0]            line;
    logic [AccumWidth-1:0] accum;
  } state_t;

  // Event flags produced by one tick.
  typedef struct packed {
    logic vblank_irq;
    logic stat_irq;
    logic render_start;
  } events_t;

endpackage

// File: design/lsmt_if.sv
// Tick channel: one beat per dot count.
interface lsmt_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] dot_count;

  modport source (output valid, output dot_count, input ready);
  modport sink (input valid, input dot_count, output ready);
endinterface

// Result channel: one beat per tick.
interface lsmt_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] cur_mode;
  logic [7:0] cur_line;
  logic       vblank_irq;
  logic       stat_irq;
  logic       render_start;

  modport source (output valid, output cur_mode, output cur_line, output vblank_irq,
                  output stat_irq, output render_start, input ready);
  modport sink (input valid, input cur_mode, input cur_line, input vblank_irq,
                input stat_irq, input render_start, output ready);
endinterface

// Configuration write channel.
interface lsmt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lsmt_pkg::CfgIdxWidth-1:0]  index;
  logic [lsmt_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/lsmt_cfg.sv
module lsmt_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  lsmt_cfg_if.sink        cfg_i,
  output lsmt_pkg::cfg_t  cfg_o
);

  lsmt_pkg::cfg_t cfg_q;
  lsmt_pkg::cfg_t cfg_d;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  // Register decode; upper data bits are masked by the field widths.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lsmt_pkg::CFG_DISPLAY_ENABLE:     cfg_d.display_enable     = cfg_i.data[0];
        lsmt_pkg::CFG_LINE_COMPARE:       cfg_d.line_compare       = cfg_i.data[7:0];
        lsmt_pkg::CFG_HBLANK_IRQ_ENABLE:  cfg_d.hblank_irq_enable  = cfg_i.data[0];
        lsmt_pkg::CFG_VBLANK_IRQ_ENABLE:  cfg_d.vblank_irq_enable  = cfg_i.data[0];
        lsmt_pkg::CFG_OAM_IRQ_ENABLE:     cfg_d.oam_irq_enable     = cfg_i.data[0];
        lsmt_pkg::CFG_COMPARE_IRQ_ENABLE: cfg_d.compare_irq_enable = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_enable     <= 1'b1;
      cfg_q.line_compare       <= 8'd0;
      cfg_q.hblank_irq_enable  <= 1'b0;
      cfg_q.vblank_irq_enable  <= 1'b0;
      cfg_q.oam_irq_enable     <= 1'b0;
      cfg_q.compare_irq_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/lsmt_step.sv
module lsmt_step (
  input  lsmt_pkg::cfg_t    cfg_i,
  input  lsmt_pkg::state_t  state_i,
  input  logic [7:0]        dot_count_i,
  output lsmt_pkg::state_t  state_o,
  output lsmt_pkg::events_t events_o
);

  logic [lsmt_pkg::AccumWidth:0]   sum;
  logic [lsmt_pkg::AccumWidth-1:0] acc_sat;
  logic [7:0]                      line_inc;
  logic                            cmp_hit;

  // Saturating add of the new dots.
  assign sum     = {1'b0, state_i.accum} + {{(lsmt_pkg::AccumWidth - 7){1'b0}}, dot_count_i};
  assign acc_sat = sum[lsmt_pkg::AccumWidth] ? lsmt_pkg::ACCUM_MAX
                                             : sum[lsmt_pkg::AccumWidth-1:0];

  // Next line wraps after the last vblank line; the compare source looks at it.
  assign line_inc = (state_i.line == lsmt_pkg::LAST_LINE) ? 8'd0 : state_i.line + 8'd1;
  assign cmp_hit  = cfg_i.compare_irq_enable && (line_inc == cfg_i.line_compare);

  // At most one phase ends per tick; the excess dots carry over.
  always_comb begin
    state_o  = state_i;
    events_o = '0;
    if (cfg_i.display_enable) begin
      state_o.accum = acc_sat;
      unique case (state_i.mode)
        lsmt_pkg::MODE_HBLANK: begin
          if (acc_sat >= lsmt_pkg::DOTS_HBLANK) begin
            state_o.accum = acc_sat - lsmt_pkg::DOTS_HBLANK;
            state_o.line  = line_inc;
            if (state_i.line < lsmt_pkg::LAST_VISIBLE_LINE) begin
              state_o.mode      = lsmt_pkg::MODE_OAM;
              events_o.stat_irq = cmp_hit || cfg_i.oam_irq_enable;
            end else begin
              state_o.mode        = lsmt_pkg::MODE_VBLANK;
              events_o.vblank_irq = 1'b1;
              events_o.stat_irq   = cmp_hit || cfg_i.vblank_irq_enable;
            end
          end
        end
        lsmt_pkg::MODE_VBLANK: begin
          if (acc_sat >= lsmt_pkg::DOTS_LINE) begin
            state_o.accum = acc_sat - lsmt_pkg::DOTS_LINE;
            state_o.line  = line_inc;
            if (state_i.line >= lsmt_pkg::LAST_LINE) begin
              state_o.mode      = lsmt_pkg::MODE_OAM;
              events_o.stat_irq = cmp_hit || cfg_i.oam_irq_enable;
            end else begin
              events_o.stat_irq = cmp_hit;
            end
          end
        end
        lsmt_pkg::MODE_OAM: begin
          if (acc_sat >= lsmt_pkg::DOTS_OAM) begin
            state_o.accum         = acc_sat - lsmt_pkg::DOTS_OAM;
            state_o.mode          = lsmt_pkg::MODE_RENDER;
            events_o.render_start = 1'b1;
          end
        end
        lsmt_pkg::MODE_RENDER: begin
          if (acc_sat >= lsmt_pkg::DOTS_RENDER) begin
            state_o.accum     = acc_sat - lsmt_pkg::DOTS_RENDER;
            state_o.mode      = lsmt_pkg::MODE_HBLANK;
            events_o.stat_irq = cfg_i.hblank_irq_enable;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/lcd_scanline_mode_timer.sv
// Channel   Dir  Beat
// tick_i    in   dot_count: dots since the previous tick
// res_o     out  cur_mode, cur_line, vblank_irq, stat_irq, render_start
// cfg_i     in   index, data: one register write
//
// A tick's result is registered after the tick is accepted: an input register, then
// the mode/line/counter update into the result register. One tick is accepted every
// cycle absent a stall; timer state is written as a tick moves into the result register.
// Reset restores display enabled, OAM search, line zero and an empty dot counter.
// A stalled result holds both stages; the input side stays ready while a stage is free.
module lcd_scanline_mode_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsmt_tick_if.sink   tick_i,
  lsmt_res_if.source  res_o,
  lsmt_cfg_if.sink    cfg_i
);

  lsmt_pkg::cfg_t    cfg;
  lsmt_pkg::state_t  state_q;
  lsmt_pkg::state_t  state_d;
  lsmt_pkg::events_t events;

  logic       in_valid_q;
  logic [7:0] in_dots_q;
  logic       out_valid_q;
  logic       out_free;
  logic       move;

  // Configuration registers.
  lsmt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Per-tick update logic.
  lsmt_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .dot_count_i (in_dots_q),
    .state_o     (state_d),
    .events_o    (events)
  );

  // Pipeline flow control.
  assign out_free     = !out_valid_q || res_o.ready;
  assign move         = in_valid_q && out_free;
  assign tick_i.ready = !in_valid_q || out_free;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_valid_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.ready && tick_i.valid) begin
      in_dots_q <= tick_i.dot_count;
    end
  end

  // Timer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= lsmt_pkg::MODE_OAM;
      state_q.line  <= 8'd0;
      state_q.accum <= '0;
    end else if (move) begin
      state_q <= state_d;
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_o.cur_mode     <= state_d.mode;
      res_o.cur_line     <= state_d.line;
      res_o.vblank_irq   <= events.vblank_irq;
      res_o.stat_irq     <= events.stat_irq;
      res_o.render_start <= events.render_start;
    end
  end

  assign res_o.valid = out_valid_q;

  // The line counter never leaves the frame.
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line <= lsmt_pkg::LAST_LINE)
    else $error("line counter beyond last line");

  // A render start beat always reports rendering mode.
  a_render_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.render_start |-> res_o.cur_mode == lsmt_pkg::MODE_RENDER)
    else $error("render start outside rendering");

  // Vblank is only entered on the first vblank line.
  a_vblank_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.vblank_irq |->
      res_o.cur_mode == lsmt_pkg::MODE_VBLANK && res_o.cur_line == 8'd144)
    else $error("vblank pulse at wrong line or mode");

  // While the display is off, a moving tick leaves the state untouched.
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && !cfg.display_enable |=> $stable(state_q))
    else $error("state changed while display disabled");

endmodule

// File: sim/lcd_scanline_mode_timer_test.sv
`timescale 1ns / 1ps

module lcd_scanline_mode_timer_test;
  import lsmt_pkg::*;

  // One beat on the result channel as the timer should report it.
  typedef struct {
    logic [1:0] mode;
    logic [7:0] line;
    logic       vblank_irq;
    logic       stat_irq;
    logic       render_start;
  } scan_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_style_e;

  logic clk_i;
  logic rst_ni;

  lsmt_tick_if tick_if ();
  lsmt_res_if  res_if ();
  lsmt_cfg_if  cfg_if ();

  lcd_scanline_mode_timer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the registers and of the timer state.
  cfg_t        cfg_shadow;
  logic [1:0]  tm_mode;
  logic [7:0]  tm_line;
  logic [9:0]  tm_accum;

  scan_result_t pending_results[$];

  // Traffic shaping, shared between the test tasks and the receiver.
  bit           gaps_on;
  int unsigned  burst_left;
  stall_style_e stall_style;
  int unsigned  hold_req;
  int unsigned  hold_left;
  int unsigned  pattern_pos;

  int unsigned fail_count;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned vblank_seen;
  int unsigned stat_seen;
  int unsigned render_seen;
  int unsigned settings_applied;
  int unsigned input_stall_cycles;

  always #6 clk_i = ~clk_i;

  // Moves the line on by one, wrapping after the last line, and reports a compare hit.
  function automatic logic step_line();
    tm_line = (tm_line == LAST_LINE) ? 8'd0 : tm_line + 8'd1;
    return (tm_line == cfg_shadow.line_compare) && cfg_shadow.compare_irq_enable;
  endfunction

  // Applies one tick to the shadow timer and returns the beat it should produce.
  function automatic scan_result_t advance_timer(logic [7:0] dots);
    scan_result_t r;
    logic [10:0]  sum;
    r.vblank_irq   = 1'b0;
    r.stat_irq     = 1'b0;
    r.render_start = 1'b0;
    if (cfg_shadow.display_enable) begin
      sum      = tm_accum + dots;
      tm_accum = (sum > ACCUM_MAX) ? ACCUM_MAX : sum[9:0];
      case (tm_mode)
        MODE_HBLANK: begin
          if (tm_accum >= DOTS_HBLANK) begin
            tm_accum -= DOTS_HBLANK;
            if (tm_line < LAST_VISIBLE_LINE) begin
              tm_mode = MODE_OAM;
              if (step_line()) r.stat_irq = 1'b1;
              if (cfg_shadow.oam_irq_enable) r.stat_irq = 1'b1;
            end else begin
              tm_mode = MODE_VBLANK;
              if (step_line()) r.stat_irq = 1'b1;
              r.vblank_irq = 1'b1;
              if (cfg_shadow.vblank_irq_enable) r.stat_irq = 1'b1;
            end
          end
        end
        MODE_VBLANK: begin
          if (tm_accum >= DOTS_LINE) begin
            tm_accum -= DOTS_LINE;
            if (tm_line >= LAST_LINE) begin
              tm_mode = MODE_OAM;
              if (step_line()) r.stat_irq = 1'b1;
              if (cfg_shadow.oam_irq_enable) r.stat_irq = 1'b1;
            end else if (step_line()) begin
              r.stat_irq = 1'b1;
            end
          end
        end
        MODE_OAM: begin
          if (tm_accum >= DOTS_OAM) begin
            tm_accum -= DOTS_OAM;
            tm_mode = MODE_RENDER;
            r.render_start = 1'b1;
          end
        end
        default: begin
          if (tm_accum >= DOTS_RENDER) begin
            tm_accum -= DOTS_RENDER;
            tm_mode = MODE_HBLANK;
            if (cfg_shadow.hblank_irq_enable) r.stat_irq = 1'b1;
          end
        end
      endcase
    end
    r.mode = tm_mode;
    r.line = tm_line;
    return r;
  endfunction

  // Dot counts leaning toward the extremes now and then.
  function automatic logic [7:0] random_dot_count();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sends one tick beat; called and returns at a falling edge.
  task automatic send_tick(input logic [7:0] dots);
    if (gaps_on && burst_left == 0) begin
      tick_if.valid = 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    tick_if.valid     = 1'b1;
    tick_if.dot_count = dots;
    do @(posedge clk_i); while (!tick_if.ready);
    pending_results.push_back(advance_timer(dots));
    ticks_sent++;
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
  endtask

  // Writes one register and leaves the write valid high; callers lower it.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_DISPLAY_ENABLE:     cfg_shadow.display_enable     = data[0];
      CFG_LINE_COMPARE:       cfg_shadow.line_compare       = data;
      CFG_HBLANK_IRQ_ENABLE:  cfg_shadow.hblank_irq_enable  = data[0];
      CFG_VBLANK_IRQ_ENABLE:  cfg_shadow.vblank_irq_enable  = data[0];
      CFG_OAM_IRQ_ENABLE:     cfg_shadow.oam_irq_enable     = data[0];
      CFG_COMPARE_IRQ_ENABLE: cfg_shadow.compare_irq_enable = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Writes all six registers, with random junk in the unused data bits.
  task automatic apply_settings(input cfg_t value);
    logic [7:0] junk;
    junk = 8'($urandom);
    write_reg(CFG_DISPLAY_ENABLE, {junk[7:1], value.display_enable});
    write_reg(CFG_LINE_COMPARE, value.line_compare);
    junk = 8'($urandom);
    write_reg(CFG_HBLANK_IRQ_ENABLE, {junk[7:1], value.hblank_irq_enable});
    junk = 8'($urandom);
    write_reg(CFG_VBLANK_IRQ_ENABLE, {junk[7:1], value.vblank_irq_enable});
    junk = 8'($urandom);
    write_reg(CFG_OAM_IRQ_ENABLE, {junk[7:1], value.oam_irq_enable});
    junk = 8'($urandom);
    write_reg(CFG_COMPARE_IRQ_ENABLE, {junk[7:1], value.compare_irq_enable});
    cfg_if.valid = 1'b0;
    settings_applied++;
  endtask

  // Stops sending and waits until every expected beat has come back.
  task automatic settle();
    tick_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Walks through OAM search, rendering and hblank at the exact thresholds,
  // then saturates the dot counter with a run of maximum counts.
  task automatic test_line_walk();
    settle();
    write_reg(CFG_LINE_COMPARE, 8'd1);
    write_reg(CFG_COMPARE_IRQ_ENABLE, 8'h01);
    write_reg(CFG_OAM_IRQ_ENABLE, 8'hFF);
    write_reg(CFG_HBLANK_IRQ_ENABLE, 8'hFF);
    write_reg(CFG_VBLANK_IRQ_ENABLE, 8'hFE);
    write_reg(CFG_DISPLAY_ENABLE, 8'h81);
    // Indexes past the last register must be ignored.
    write_reg(3'd6, 8'hFF);
    write_reg(3'd7, 8'h00);
    cfg_if.valid = 1'b0;
    settings_applied++;
    gaps_on     = 1'b0;
    stall_style = STALL_NONE;
    send_tick(8'd0);
    send_tick(8'd79);
    send_tick(8'd1);
    send_tick(8'd255);
    send_tick(8'd35);
    send_tick(8'd1);
    send_tick(8'd84);
    send_tick(8'd1);
    repeat (12) send_tick(8'd255);
    send_tick(8'd0);
    settle();
  endtask

  // With the display off nothing may move and no pulse may fire.
  task automatic test_display_freeze();
    settle();
    write_reg(CFG_DISPLAY_ENABLE, 8'hFE);
    cfg_if.valid = 1'b0;
    gaps_on     = 1'b1;
    stall_style = STALL_RANDOM;
    repeat (16) send_tick(random_dot_count());
    settle();
    write_reg(CFG_DISPLAY_ENABLE, 8'h01);
    cfg_if.valid = 1'b0;
    settings_applied++;
  endtask

  // Long random runs through whole frames under a series of register settings.
  task automatic test_random_timing();
    cfg_t        setting;
    logic [7:0]  compare_pick [6];
    logic [3:0]  enables;
    compare_pick = '{8'd0, 8'd255, 8'd153, 8'd144, 8'd143, 8'd0};
    compare_pick[5] = 8'($urandom_range(0, 153));
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0:       enables = 4'b0000;
        1:       enables = 4'b1111;
        2:       enables = 4'b1010;
        default: enables = 4'($urandom);
      endcase
      setting.display_enable     = 1'b1;
      setting.line_compare       = compare_pick[phase];
      setting.hblank_irq_enable  = enables[0];
      setting.vblank_irq_enable  = enables[1];
      setting.oam_irq_enable     = enables[2];
      setting.compare_irq_enable = enables[3];
      apply_settings(setting);
      case (phase % 3)
        0: begin
          gaps_on     = 1'b0;
          stall_style = STALL_NONE;
        end
        1: begin
          gaps_on     = 1'b1;
          stall_style = STALL_RANDOM;
        end
        default: begin
          gaps_on     = 1'b1;
          stall_style = STALL_PATTERN;
        end
      endcase
      repeat (270) send_tick(random_dot_count());
    end
    settle();
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so
  // both stages fill and the tick channel has to stall.
  task automatic test_result_backpressure();
    settle();
    gaps_on     = 1'b0;
    stall_style = STALL_NONE;
    hold_req    = 150;
    repeat (40) send_tick(random_dot_count());
    settle();
  endtask

  // Result side: ready follows the current stall style or a requested hold-off.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    pattern_pos = (pattern_pos + 1) % 9;
    if (hold_left != 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      case (stall_style)
        STALL_RANDOM:  res_if.ready = ($urandom_range(0, 99) >= 30);
        STALL_PATTERN: res_if.ready = !(pattern_pos inside {2, 3, 7});
        default:       res_if.ready = 1'b1;
      endcase
    end
  end

  // Compares each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    scan_result_t want;
    if (rst_ni) begin
      if (tick_if.valid && !tick_if.ready) input_stall_cycles++;
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no tick waiting for it");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("cur_mode", want.mode, res_if.cur_mode);
          check_field("cur_line", want.line, res_if.cur_line);
          check_field("vblank_irq", want.vblank_irq, res_if.vblank_irq);
          check_field("stat_irq", want.stat_irq, res_if.stat_irq);
          check_field("render_start", want.render_start, res_if.render_start);
          results_checked++;
          if (res_if.vblank_irq) vblank_seen++;
          if (res_if.stat_irq) stat_seen++;
          if (res_if.render_start) render_seen++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    tick_if.valid     = 1'b0;
    tick_if.dot_count = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    gaps_on           = 1'b0;
    burst_left        = 0;
    stall_style       = STALL_NONE;
    hold_req          = 0;
    hold_left         = 0;
    pattern_pos       = 0;

    // Reset values of the registers and the timer.
    cfg_shadow.display_enable     = 1'b1;
    cfg_shadow.line_compare       = 8'd0;
    cfg_shadow.hblank_irq_enable  = 1'b0;
    cfg_shadow.vblank_irq_enable  = 1'b0;
    cfg_shadow.oam_irq_enable     = 1'b0;
    cfg_shadow.compare_irq_enable = 1'b0;
    tm_mode  = MODE_OAM;
    tm_line  = 8'd0;
    tm_accum = '0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_line_walk();
    test_display_freeze();
    test_random_timing();
    test_result_backpressure();
    settle();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d of %0d ticks under %0d register settings.",
             results_checked, ticks_sent, settings_applied);
    $display("Saw %0d vblank, %0d STAT and %0d render-start pulses; %0d stalled tick cycles.",
             vblank_seen, stat_seen, render_seen, input_stall_cycles);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
